// File: rtl/task_run_queue_macros.svh
// assertion macros for the task run queue
// uses the clk and arst_n names of the module that expands them
`ifndef TASK_RUN_QUEUE_MACROS_SVH
`define TASK_RUN_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define TRQ_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("trq check failed");
`define TRQ_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("trq sequence check failed");
`else
`define TRQ_ASSERT(lbl, cond)
`define TRQ_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// File: rtl/trq_pkg.sv
// shared types and constants for the task run queue
// no dependencies
package trq_pkg;

	localparam int MASK_W = 8;
	localparam int IDX_W  = 3;
	localparam int CNT_W  = 4;

	typedef logic [IDX_W-1:0] trq_idx_t;
	typedef logic [CNT_W-1:0] trq_cnt_t;
	typedef logic [MASK_W-1:0] trq_mask_t;

	typedef struct packed {
		logic     load;
		logic     step;
		logic     finish;
		trq_idx_t task_idx;
	} trq_cmd_t;

	typedef struct packed {
		logic out_free;
	} trq_stat_t;

endpackage

// File: rtl/task_run_queue.sv
// task run queue top level: sequencer plus queue datapath
// depends on trq_pkg, trq_ctrl, trq_datapath
//
// One request on the s_ side carries an add mask and a remove mask for one
// scheduler tick. The block walks the tasks from index 0 upward, one task per
// clock: a task is dropped from the queue if its remove bit is set or it was
// dispatched on the previous tick, then appended at the tail if its add bit is
// set and it is absent. After the walk the head task is reported and marked
// as dispatched for the next tick.
// Sequence: the request is taken in the idle state, the walk then steps through
// min(TASK_COUNT, 8) tasks, and the result is then loaded into the output
// register from the done state. s_tready is high only between ticks.
// The result waits in the output register; while m_tready is low the next
// request is still accepted and walked, and the block holds before loading
// its result until the previous one has been taken.
// Reset empties the queue and clears the dispatched task; no result is pending.
module task_run_queue
	import trq_pkg::*;
#(
	parameter int TASK_COUNT = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [2*MASK_W-1:0] s_tdata,  // add_mask [7:0], remove_mask [15:8]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,  // run_task [2:0], queue_count [6:3], zero [7]
	output logic                m_tuser   // run_valid [0]
);

	localparam int SlotCount = (TASK_COUNT < MASK_W) ? TASK_COUNT : MASK_W;

	trq_cmd_t  cmd;
	trq_stat_t stat;

	trq_ctrl #(
		.SLOT_COUNT(SlotCount)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	trq_datapath #(
		.SLOT_COUNT(SlotCount)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.cmd     (cmd),
		.stat    (stat),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

// File: rtl/trq_ctrl.sv
// sequencer for the task run queue: accept, one step per task, result hand-off
// depends on trq_pkg and task_run_queue_macros.svh
`include "task_run_queue_macros.svh"
module trq_ctrl
	import trq_pkg::*;
#(
	parameter int SLOT_COUNT = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  trq_stat_t stat,
	output trq_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_STEP = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam trq_idx_t LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	logic [1:0] state_q;
	logic [1:0] state_d;
	trq_idx_t   task_q;
	trq_idx_t   task_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		task_d       = task_q;
		cmd.load     = 1'b0;
		cmd.step     = 1'b0;
		cmd.finish   = 1'b0;
		cmd.task_idx = task_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					task_d   = '0;
					state_d  = ST_STEP;
				end
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				if (task_q == LAST_IDX) begin
					state_d = ST_DONE;
				end else begin
					task_d = task_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			task_q  <= '0;
		end else begin
			state_q <= state_d;
			task_q  <= task_d;
		end
	end

	`TRQ_ASSERT_NEXT(a_load_starts_pass, cmd.load, state_q == ST_STEP && task_q == '0)
	`TRQ_ASSERT_NEXT(a_last_step_done, cmd.step && task_q == LAST_IDX, state_q == ST_DONE)
	`TRQ_ASSERT(a_step_in_range, !cmd.step || task_q <= LAST_IDX)

endmodule

// File: rtl/trq_datapath.sv
// queue storage, per-task remove/append step and output register
// depends on trq_pkg and task_run_queue_macros.svh
`include "task_run_queue_macros.svh"
module trq_datapath
	import trq_pkg::*;
#(
	parameter int SLOT_COUNT = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [2*MASK_W-1:0] s_tdata,
	input  trq_cmd_t            cmd,
	output trq_stat_t           stat,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,
	output logic                m_tuser
);

	trq_mask_t add_q;
	trq_mask_t rem_q;
	trq_mask_t disp_q;
	trq_cnt_t  cnt_q;
	trq_idx_t  list_q [SLOT_COUNT];
	trq_idx_t  list_d [SLOT_COUNT];
	trq_idx_t  shift_src [SLOT_COUNT];

	logic                 out_valid_q;
	logic                 run_valid_q;
	trq_idx_t             run_task_q;
	trq_cnt_t             queue_count_q;

	logic [SLOT_COUNT-1:0] hit;
	logic [SLOT_COUNT-1:0] shift_en;
	logic                 present;
	logic                 remove;
	logic                 append;
	trq_cnt_t             cnt_mid;
	trq_cnt_t             cnt_d;

	genvar g;
	generate
		for (g = 0; g < SLOT_COUNT; g++) begin : g_src
			if (g + 1 < SLOT_COUNT) begin : g_next
				assign shift_src[g] = list_q[g+1];
			end else begin : g_end
				assign shift_src[g] = list_q[g];
			end
		end
	endgenerate

	always_comb begin
		for (int k = 0; k < SLOT_COUNT; k++) begin
			hit[k] = (CNT_W'(k) < cnt_q) && (list_q[k] == cmd.task_idx);
		end
		present = |hit;
		remove  = present && (rem_q[cmd.task_idx] || disp_q[cmd.task_idx]);
		shift_en[0] = remove && hit[0];
		for (int k = 1; k < SLOT_COUNT; k++) begin
			shift_en[k] = shift_en[k-1] || (remove && hit[k]);
		end
		cnt_mid = cnt_q - CNT_W'(remove);
		append  = add_q[cmd.task_idx] && !(present && !remove)
			&& (cnt_mid < CNT_W'(SLOT_COUNT));
		cnt_d   = cnt_mid + CNT_W'(append);
		for (int k = 0; k < SLOT_COUNT; k++) begin
			list_d[k] = shift_en[k] ? shift_src[k] : list_q[k];
			if (append && cnt_mid == CNT_W'(k)) begin
				list_d[k] = cmd.task_idx;
			end
		end
	end

	// queue order, head at entry 0
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			for (int k = 0; k < SLOT_COUNT; k++) begin
				list_q[k] <= list_d[k];
			end
		end
		if (cmd.load) begin
			add_q <= s_tdata[MASK_W-1:0];
			rem_q <= s_tdata[2*MASK_W-1:MASK_W];
		end
		if (cmd.finish) begin
			run_valid_q   <= (cnt_q != '0);
			run_task_q    <= (cnt_q != '0) ? list_q[0] : '0;
			queue_count_q <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			disp_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.step) begin
				cnt_q <= cnt_d;
			end
			if (cmd.finish) begin
				disp_q      <= (cnt_q != '0) ? (MASK_W'(1) << list_q[0]) : '0;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_free = !out_valid_q || m_tready;
	assign m_tvalid      = out_valid_q;
	assign m_tuser       = run_valid_q;
	assign m_tdata       = {1'b0, queue_count_q, run_task_q};

	`TRQ_ASSERT(a_count_bound, cnt_q <= CNT_W'(SLOT_COUNT))
	`TRQ_ASSERT(a_finish_when_free, !cmd.finish || stat.out_free)
	`TRQ_ASSERT_NEXT(a_finish_shows, cmd.finish, m_tvalid && (m_tuser == (queue_count_q != '0)))

endmodule

// File: tb/task_run_queue_tb.sv
// testbench for the task run queue: directed and random add/remove mask requests
// under several sender and receiver idling phases, each result checked against
// a local queue predictor; depends on trq_pkg and task_run_queue
`timescale 1ns / 100ps

module task_run_queue_tb;
	import trq_pkg::*;

	localparam int TASKS = 8;

	typedef struct packed {
		logic     run_valid;
		trq_idx_t run_task;
		trq_cnt_t queue_count;
	} run_report_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid;
	logic                s_tready;
	logic [2*MASK_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [7:0]          m_tdata;
	logic                m_tuser;

	logic [2*MASK_W-1:0] req_q[$];
	run_report_t         dispatch_q[$];
	trq_idx_t            run_order[$];
	trq_mask_t           last_run = '0;
	int                  send_idle_pct = 0;
	int                  recv_stall_pct = 0;
	int                  fail_count = 0;

	task_run_queue #(
		.TASK_COUNT(TASKS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic run_report_t schedule_tick(input trq_mask_t add_m, input trq_mask_t rem_m);
		run_report_t rep;
		int          pos;
		for (int i = 0; i < TASKS; i++) begin
			pos = -1;
			foreach (run_order[k])
				if (run_order[k] == trq_idx_t'(i))
					pos = k;
			// drop on remove request or when dispatched last tick
			if ((rem_m[i] || last_run[i]) && pos >= 0) begin
				run_order.delete(pos);
				pos = -1;
			end
			if (add_m[i] && pos < 0 && run_order.size() < TASKS)
				run_order.push_back(trq_idx_t'(i));
		end
		rep.queue_count = trq_cnt_t'(run_order.size());
		if (run_order.size() > 0) begin
			rep.run_valid = 1'b1;
			rep.run_task  = run_order[0];
			last_run      = trq_mask_t'(1) << run_order[0];
		end else begin
			rep.run_valid = 1'b0;
			rep.run_task  = '0;
			last_run      = '0;
		end
		return rep;
	endfunction

	task automatic push_req(input trq_mask_t add_m, input trq_mask_t rem_m);
		req_q.push_back({rem_m, add_m});
	endtask

	task automatic push_random_req();
		int        sel;
		trq_mask_t add_m;
		trq_mask_t rem_m;
		sel = $urandom_range(99);
		if (sel < 10) begin
			add_m = trq_mask_t'($urandom);
			rem_m = trq_mask_t'($urandom);
		end else if (sel < 16) begin
			add_m = (sel < 13) ? 8'hFF : trq_mask_t'($urandom);
			rem_m = (sel < 13) ? trq_mask_t'($urandom & $urandom) : 8'hFF;
		end else begin
			// sparse masks keep the queue partly full most of the time
			add_m = trq_mask_t'($urandom & $urandom);
			rem_m = trq_mask_t'($urandom & $urandom & $urandom);
		end
		push_req(add_m, rem_m);
	endtask

	task automatic wait_drained();
		while (req_q.size() > 0 || s_tvalid || dispatch_q.size() > 0)
			@(negedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				dispatch_q.push_back(schedule_tick(s_tdata[MASK_W-1:0], s_tdata[2*MASK_W-1:MASK_W]));
			if (!s_tvalid || s_tready) begin
				if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= req_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		run_report_t exp_r;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (dispatch_q.size() == 0) begin
					fail_count++;
					$display("%0t unexpected result: run_valid %0d run_task %0d queue_count %0d",
						$time, m_tuser, m_tdata[2:0], m_tdata[6:3]);
				end else begin
					exp_r = dispatch_q.pop_front();
					if (m_tuser !== exp_r.run_valid || m_tdata[2:0] !== exp_r.run_task ||
						m_tdata[6:3] !== exp_r.queue_count) begin
						fail_count++;
						if (fail_count <= 50) begin
							if (m_tuser !== exp_r.run_valid)
								$display("%0t run_valid mismatch: expected %0d actual %0d",
									$time, exp_r.run_valid, m_tuser);
							if (m_tdata[2:0] !== exp_r.run_task)
								$display("%0t run_task mismatch: expected %0d actual %0d",
									$time, exp_r.run_task, m_tdata[2:0]);
							if (m_tdata[6:3] !== exp_r.queue_count)
								$display("%0t queue_count mismatch: expected %0d actual %0d",
									$time, exp_r.queue_count, m_tdata[6:3]);
						end
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		// empty queue, then fill and drain
		push_req(8'h00, 8'h00);
		push_req(8'h01, 8'h00);
		push_req(8'hFF, 8'h00);
		push_req(8'h00, 8'h00);
		push_req(8'h00, 8'hFF);
		// removal of absent tasks
		push_req(8'hAA, 8'h55);
		// add and remove together on absent tasks
		push_req(8'h55, 8'h55);
		push_req(8'h0F, 8'h00);
		// add of present tasks keeps their place
		push_req(8'h0F, 8'h00);
		// add and remove together moves to the tail
		push_req(8'hF0, 8'hF0);
		push_req(8'h00, 8'hFF);
		push_req(8'h00, 8'h00);
		push_req(8'h80, 8'h00);
		// dispatched task added again
		push_req(8'h80, 8'h00);
		push_req(8'hFF, 8'hFF);
		push_req(8'h00, 8'hFF);
		push_req(8'h01, 8'h80);
		push_req(8'hFF, 8'h00);
		push_req(8'hFF, 8'h00);
		push_req(8'h00, 8'h00);
		push_req(8'h00, 8'h00);
		push_req(8'h00, 8'h00);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 63;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 63;
				end
				default: begin
					send_idle_pct  = 37;
					recv_stall_pct = 37;
				end
			endcase
			repeat (382) push_random_req();
			wait_drained();
		end

		repeat (30) @(negedge clk);
		if (fail_count == 0)
			$display("PASS task_run_queue");
		else
			$display("FAIL task_run_queue");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL task_run_queue");
		$finish;
	end

endmodule
